// ===== rtl/core/bitmap_video_layer_macros.svh =====
// ----------------------------------------------------------------------------
// Bitmap video layer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BITMAP_VIDEO_LAYER_MACROS_SVH
`define BITMAP_VIDEO_LAYER_MACROS_SVH

// same-cycle implication
`define BVL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BVL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bvl_pkg.sv =====
// ----------------------------------------------------------------------------
// bvl_pkg
// Types and constants shared by the bitmap video layer modules.
// ----------------------------------------------------------------------------
package bvl_pkg;

  localparam int ADDR_W        = 18;
  localparam int STORE_DEPTH   = 1 << ADDR_W;
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int ROW_SHIFT     = 9;       // row pitch of 512 words
  localparam int CMD_DEPTH     = 4;

  localparam logic [ADDR_W-1:0] SCREEN_OFFSET = 18'h20000;
  localparam logic [15:0]       STATUS_WORD   = 16'h0060;

  // bus / pixel op codes
  localparam logic [2:0] OP_RAM_RD  = 3'd0;
  localparam logic [2:0] OP_RAM_WR  = 3'd1;
  localparam logic [2:0] OP_CTRL_WR = 3'd2;
  localparam logic [2:0] OP_CTRL_RD = 3'd3;
  localparam logic [2:0] OP_MASK_WR = 3'd4;
  localparam logic [2:0] OP_PIXEL   = 3'd5;

  // resolved command kinds, front to back
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_READ   = 3'd1;
  localparam logic [2:0] CMD_WRITE  = 3'd2;
  localparam logic [2:0] CMD_STATUS = 3'd3;
  localparam logic [2:0] CMD_PIXEL  = 3'd4;

  typedef struct packed {
    logic [2:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       wdata;
    logic [1:0]        lanes;
    logic [8:0]        px;
    logic [7:0]        py;
  } bvl_in_t;

  typedef struct packed {
    logic [15:0] rdata;
    logic [11:0] color;
  } bvl_out_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       data;
    logic [15:0]       change;
  } bvl_cmd_t;

endpackage

// ===== rtl/core/bvl_front.sv =====
// ----------------------------------------------------------------------------
// bvl_front
// Accepts bus and pixel transactions, applies register writes and resolves
// each transaction into a command for the back end.
// ----------------------------------------------------------------------------
module bvl_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic             q_full,
  input  bvl_pkg::bvl_in_t in_item,
  output logic             cmd_push,
  output bvl_pkg::bvl_cmd_t cmd
);

  logic [15:0] control_word_r, control_word_nxt;
  logic [15:0] write_mask_r, write_mask_nxt;
  logic [15:0] lane_bits;
  logic [bvl_pkg::ADDR_W-1:0] pix_addr;
  logic        on_screen;

  assign cmd_push  = push && !q_full;
  assign lane_bits = {{8{in_item.lanes[1]}}, {8{in_item.lanes[0]}}};

  assign on_screen = ({1'b0, in_item.px} < 10'(bvl_pkg::SCREEN_WIDTH)) &&
                     ({2'b00, in_item.py} < 10'(bvl_pkg::SCREEN_HEIGHT));

  assign pix_addr = (control_word_r[0] ? bvl_pkg::SCREEN_OFFSET : '0)
                  + (bvl_pkg::ADDR_W'(in_item.py) << bvl_pkg::ROW_SHIFT)
                  + bvl_pkg::ADDR_W'(in_item.px)
                  + bvl_pkg::ADDR_W'(1);

  always_comb begin
    cmd.kind         = bvl_pkg::CMD_NONE;
    cmd.addr         = in_item.addr;
    cmd.data         = in_item.wdata;
    cmd.change       = lane_bits & write_mask_r;
    control_word_nxt = control_word_r;
    write_mask_nxt   = write_mask_r;
    unique case (in_item.op)
      bvl_pkg::OP_RAM_RD:  cmd.kind = bvl_pkg::CMD_READ;
      bvl_pkg::OP_RAM_WR:  cmd.kind = bvl_pkg::CMD_WRITE;
      bvl_pkg::OP_CTRL_WR: begin
        control_word_nxt = (control_word_r & ~lane_bits) | (in_item.wdata & lane_bits);
      end
      bvl_pkg::OP_CTRL_RD: cmd.kind = bvl_pkg::CMD_STATUS;
      bvl_pkg::OP_MASK_WR: begin
        write_mask_nxt = (write_mask_r & ~lane_bits) | (in_item.wdata & lane_bits);
      end
      bvl_pkg::OP_PIXEL: begin
        cmd.addr = pix_addr;
        if (on_screen) begin
          cmd.kind = bvl_pkg::CMD_PIXEL;
        end
      end
      default: cmd.kind = bvl_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_word_r <= '0;
      write_mask_r   <= '0;
    end else if (cmd_push) begin
      control_word_r <= control_word_nxt;
      write_mask_r   <= write_mask_nxt;
    end
  end

endmodule

// ===== rtl/core/bvl_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// bvl_cmd_fifo
// Short show-ahead command queue between front and back end.
// ----------------------------------------------------------------------------
module bvl_cmd_fifo #(
  parameter int DEPTH = bvl_pkg::CMD_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  bvl_pkg::bvl_cmd_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output logic              rd_valid,
  output bvl_pkg::bvl_cmd_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bvl_pkg::bvl_cmd_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = slot_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= bump(wr_ptr_r);
      if (do_rd) rd_ptr_r <= bump(rd_ptr_r);
      if (do_wr && !do_rd) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/bvl_back.sv =====
// ----------------------------------------------------------------------------
// bvl_back
// Video RAM, masked read-modify-write, pixel decode and result register.
// ----------------------------------------------------------------------------
module bvl_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  bvl_pkg::bvl_cmd_t cmd,
  output logic              cmd_pop,
  output logic              empty,
  input  logic              pop,
  output bvl_pkg::bvl_out_t out_item
);

  `include "bitmap_video_layer_macros.svh"

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DATA = 1'b1;

  logic [15:0] vram [bvl_pkg::STORE_DEPTH];

  logic              state_r, state_nxt;
  bvl_pkg::bvl_cmd_t cmd_r;
  logic [15:0]       rd_data_r;
  logic              out_valid_r, out_valid_nxt;
  bvl_pkg::bvl_out_t out_r, res_nxt;
  logic              slot_free, finish, mem_we;
  logic [15:0]       merged;

  function automatic logic [11:0] decode_color(input logic [15:0] w);
    logic [11:0] c;
    c = {1'b0, w[8:6], 8'h00};
    if (w[15]) begin
      c[11]  = 1'b1;
      c[3:0] = w[13] ? 4'h0 : w[12:9];
    end else begin
      c[3:0] = w[3:0];
    end
    return c;
  endfunction

  assign slot_free = !out_valid_r || pop;
  assign cmd_pop   = (state_r == ST_IDLE) && cmd_valid;
  assign finish    = (state_r == ST_DATA) && slot_free;
  assign mem_we    = finish && (cmd_r.kind == bvl_pkg::CMD_WRITE);
  assign merged    = (rd_data_r & ~cmd_r.change) | (cmd_r.data & cmd_r.change);

  assign empty    = !out_valid_r;
  assign out_item = out_r;

  always_comb begin
    res_nxt = '0;
    unique case (cmd_r.kind)
      bvl_pkg::CMD_READ:   res_nxt.rdata = rd_data_r;
      bvl_pkg::CMD_STATUS: res_nxt.rdata = bvl_pkg::STATUS_WORD;
      bvl_pkg::CMD_PIXEL:  res_nxt.color = decode_color(rd_data_r);
      default:             res_nxt = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (cmd_valid) state_nxt = ST_DATA;
      ST_DATA: if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = finish ? 1'b1 : (pop ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vram[cmd_r.addr] <= merged;
    end
    if (cmd_pop) begin
      rd_data_r <= vram[cmd.addr];
      cmd_r     <= cmd;
    end
    if (finish) begin
      out_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `BVL_ASSERT_NOW(a_finish_slot, clk, rst_n, finish, !out_valid_r || pop, "result overwrites unread result")
  `BVL_ASSERT_NEXT(a_hold_read, clk, rst_n, (state_r == ST_DATA) && !slot_free, $stable(rd_data_r) && $stable(cmd_r), "read data lost while stalled")
  `BVL_ASSERT_NEXT(a_start_to_data, clk, rst_n, cmd_pop, (state_r == ST_DATA) && !cmd_pop, "command issued without data phase")
  `BVL_ASSERT_NEXT(a_color_only_pixel, clk, rst_n, finish && (cmd_r.kind != bvl_pkg::CMD_PIXEL), out_r.color == 12'h000, "colour on non-pixel result")

endmodule

// ===== rtl/core/bitmap_video_layer.sv =====
// ----------------------------------------------------------------------------
// bitmap_video_layer
// A result passes through the command queue, the back end's read register and the result register.
// The back end's single RAM port does a read and then the masked write-back
// (or result capture) for each transaction before it takes the next one.
// Reset: control word, write mask, queue and result valid flag clear; the video
// RAM is not cleared and needs no sweep, so transactions are taken at once.
// ----------------------------------------------------------------------------
module bitmap_video_layer #(
  parameter int CMD_DEPTH = bvl_pkg::CMD_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  // input transaction queue side
  input  logic              push,
  output logic              full,
  input  bvl_pkg::bvl_in_t  in_item,
  // result queue side
  output logic              empty,
  input  logic              pop,
  output bvl_pkg::bvl_out_t out_item
);

  // Front end: register writes (control, mask) land here in transaction order,
  // so every command in the queue already carries its resolved RAM address
  // (screen select applied) and its bit-change mask (lanes AND write mask).
  logic              cmd_push;
  bvl_pkg::bvl_cmd_t cmd_in;

  // Queue output towards the back end
  logic              cmd_valid;
  logic              cmd_pop;
  bvl_pkg::bvl_cmd_t cmd_out;

  bvl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .q_full   (full),
    .in_item  (in_item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  // The short queue lets the bus keep pushing while a result waits unread.
  bvl_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cmd_push),
    .wr_data  (cmd_in),
    .full     (full),
    .rd_en    (cmd_pop),
    .rd_valid (cmd_valid),
    .rd_data  (cmd_out)
  );

  // Back end: one command at a time; RAM read, then write-back of the merged
  // word for bus writes, or capture of RAM word / status / pixel colour.
  bvl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule

// ===== tb/bitmap_video_layer_checker.sv =====
// ----------------------------------------------------------------------------
// Bitmap video layer result checker
// Watches both queue sides of the layer. It predicts every result from its own
// copy of the video RAM, control word and write mask, then compares each
// popped result with the oldest prediction.
// ----------------------------------------------------------------------------
module bvl_result_checker
  import bvl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  logic     full,
  input  bvl_in_t  in_item,
  input  logic     empty,
  input  logic     pop,
  input  bvl_out_t out_item,
  output int       fail_count,
  output int       waiting,
  output int       compared
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] vram [logic [ADDR_W-1:0]];
  logic [15:0] ctrl_word;
  logic [15:0] mask_word;
  bvl_out_t    due_results [$];
  logic [2:0]  due_ops [$];
  bvl_out_t    want;
  logic [2:0]  want_op;

  initial begin
    ctrl_word  = '0;
    mask_word  = '0;
    fail_count = 0;
    waiting    = 0;
    compared   = 0;
  end

  function automatic logic [15:0] vram_word(input logic [ADDR_W-1:0] a);
    return vram.exists(a) ? vram[a] : 16'h0000;
  endfunction

  // 12-bit palette index; bit 13 wipes the low nibble of high-bank colours
  function automatic logic [11:0] palette_index(input logic [15:0] w);
    logic [11:0] c;
    c = '0;
    c[10:8] = w[8:6];
    if (w[15]) begin
      c[11]  = 1'b1;
      c[3:0] = w[13] ? 4'h0 : w[12:9];
    end else begin
      c[3:0] = w[3:0];
    end
    return c;
  endfunction

  task automatic step_video_ram(input bvl_in_t it);
    bvl_out_t          res;
    logic [15:0]       lw;
    logic [15:0]       chg;
    logic [ADDR_W-1:0] a;
    res = '0;
    lw  = {{8{it.lanes[1]}}, {8{it.lanes[0]}}};
    case (it.op)
      OP_RAM_RD: res.rdata = vram_word(it.addr);
      OP_RAM_WR: begin
        chg = lw & mask_word;
        vram[it.addr] = (vram_word(it.addr) & ~chg) | (it.wdata & chg);
      end
      OP_CTRL_WR: ctrl_word = (ctrl_word & ~lw) | (it.wdata & lw);
      OP_CTRL_RD: res.rdata = STATUS_WORD;
      OP_MASK_WR: mask_word = (mask_word & ~lw) | (it.wdata & lw);
      OP_PIXEL: begin
        if (it.px < SCREEN_WIDTH && it.py < SCREEN_HEIGHT) begin
          a = (ctrl_word[0] ? SCREEN_OFFSET : '0) + {it.py, 9'd0} + it.px + 18'd1;
          res.color = palette_index(vram_word(a));
        end
      end
      default: ;
    endcase
    due_results.push_back(res);
    due_ops.push_back(it.op);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ctrl_word = '0;
      mask_word = '0;
      due_results.delete();
      due_ops.delete();
    end else begin
      if (push && !full)
        step_video_ram(in_item);
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing outstanding: rdata %04h color %03h",
                   $time, out_item.rdata, out_item.color);
        end else begin
          want    = due_results.pop_front();
          want_op = due_ops.pop_front();
          compared++;
          if (out_item.rdata !== want.rdata) begin
            fail_count++;
            $display("%0t: op %0d rdata expected %04h, got %04h",
                     $time, want_op, want.rdata, out_item.rdata);
          end
          if (out_item.color !== want.color) begin
            fail_count++;
            $display("%0t: op %0d color expected %03h, got %03h",
                     $time, want_op, want.color, out_item.color);
          end
        end
      end
    end
    waiting = due_results.size();
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Bitmap video layer testbench
// Drives bus and pixel transactions into the layer through its input queue
// and drains results at random. A side checker predicts and compares; this
// top only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bvl_pkg::*;

  // op codes the block leaves unused
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int RANDOM_PER_PHASE = 500;
  localparam int PRELOAD_WORDS    = 40;
  localparam int DRAIN_CYCLES     = 16;
  localparam int STALL_LIMIT      = 4000;

  logic     clk;
  logic     rst_n   = 1'b0;
  logic     push    = 1'b0;
  logic     pop     = 1'b0;
  bvl_in_t  in_item = '0;
  logic     full;
  logic     empty;
  bvl_out_t out_item;

  int fail_count;
  int waiting;
  int compared;

  // idling odds in percent, changed per phase
  int send_idle_pct = 0;
  int take_idle_pct = 0;

  // stimulus-side view of the state: enough to steer clear of undefined RAM
  logic [15:0]       ctrl_now = '0;
  logic [15:0]       mask_now = '0;
  logic [ADDR_W-1:0] known_addrs [$];
  bit                is_known [logic [ADDR_W-1:0]];
  int                op_seen [8];
  int                stall_run = 0;

  bitmap_video_layer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  bvl_result_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item   (out_item),
    .fail_count (fail_count),
    .waiting    (waiting),
    .compared   (compared)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: stalls at random at the rate of the current phase
  always @(posedge clk) begin
    pop <= rst_n && ($urandom_range(0, 99) >= take_idle_pct);
  end

  // watchdog: a run of cycles with no transaction on either side means a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty))
        stall_run <= 0;
      else
        stall_run <= stall_run + 1;
      if (stall_run >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("bitmap_video_layer test failed");
        $finish;
      end
    end
  end

  function automatic bvl_in_t mk(input logic [2:0] op, input logic [ADDR_W-1:0] addr,
                                 input logic [15:0] wdata, input logic [1:0] lanes,
                                 input logic [8:0] px, input logic [7:0] py);
    bvl_in_t it;
    it.op    = op;
    it.addr  = addr;
    it.wdata = wdata;
    it.lanes = lanes;
    it.px    = px;
    it.py    = py;
    return it;
  endfunction

  // full-word write to a random address, mostly one that maps to a pixel
  // of either screen; every other field is noise
  function automatic bvl_in_t fresh_write();
    bvl_in_t it;
    bit      scr;
    it.op    = OP_RAM_WR;
    it.addr  = ADDR_W'($urandom_range(0, STORE_DEPTH - 1));
    it.wdata = 16'($urandom);
    it.lanes = 2'b11;
    it.px    = 9'($urandom_range(0, 510));
    it.py    = 8'($urandom);
    scr      = 1'($urandom);
    if ($urandom_range(0, 9) < 7)
      it.addr = {scr, 17'd0} + {8'($urandom_range(0, SCREEN_HEIGHT - 1)), 9'd0}
                + ADDR_W'($urandom_range(0, SCREEN_WIDTH - 1)) + 18'd1;
    return it;
  endfunction

  function automatic bvl_in_t random_item();
    bvl_in_t           it;
    int                r;
    bit                found;
    logic [ADDR_W-1:0] off;
    it    = fresh_write();
    r     = $urandom_range(0, 99);
    found = 1'b0;
    if (r < 10) begin
      if ($urandom_range(0, 3) == 0)
        it.lanes = 2'($urandom);
    end else begin
      it.lanes = 2'($urandom);
      if (r < 35) begin
        it.op   = OP_RAM_WR;
        it.addr = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
      end else if (r < 55) begin
        it.op   = OP_RAM_RD;
        it.addr = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
      end else if (r < 80) begin
        it.op = OP_PIXEL;
        // mostly on-screen: back a known word out to its pixel position
        if ($urandom_range(0, 99) < 85) begin
          for (int tries = 0; tries < 8; tries++) begin
            off = known_addrs[$urandom_range(0, known_addrs.size() - 1)]
                  - (ctrl_now[0] ? SCREEN_OFFSET : 18'd0) - 18'd1;
            if (off[8:0] < SCREEN_WIDTH && off[17:9] < SCREEN_HEIGHT) begin
              it.px = off[8:0];
              it.py = off[16:9];
              found = 1'b1;
              break;
            end
          end
        end
        if (!found) begin
          if ($urandom_range(0, 1))
            it.px = 9'($urandom_range(SCREEN_WIDTH, 510));
          else
            it.py = 8'($urandom_range(SCREEN_HEIGHT, 255));
        end
      end else if (r < 85) begin
        it.op = OP_CTRL_WR;
      end else if (r < 90) begin
        it.op = OP_CTRL_RD;
      end else if (r < 96) begin
        it.op = OP_MASK_WR;
        if ($urandom_range(0, 1)) begin
          it.wdata = 16'hFFFF;
          it.lanes = 2'b11;
        end
      end else begin
        it.op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
      end
    end
    return it;
  endfunction

  // track state, then hold the transaction on the input queue until taken
  task automatic issue(input bvl_in_t it);
    logic [15:0] lw;
    lw = {{8{it.lanes[1]}}, {8{it.lanes[0]}}};
    case (it.op)
      OP_RAM_WR: begin
        // a word counts as defined once all 16 bits have been written
        if ((lw & mask_now) == 16'hFFFF && !is_known.exists(it.addr)) begin
          is_known[it.addr] = 1'b1;
          known_addrs.push_back(it.addr);
        end
      end
      OP_CTRL_WR: ctrl_now = (ctrl_now & ~lw) | (it.wdata & lw);
      OP_MASK_WR: mask_now = (mask_now & ~lw) | (it.wdata & lw);
      default: ;
    endcase
    op_seen[it.op]++;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: status, mask lanes, byte-masked writes, address extremes,
    // screen edges, both screens and the bit 13 nibble clear
    issue(mk(OP_CTRL_RD, 18'h3FFFF, 16'hFFFF, 2'b11, 9'd510, 8'd255));
    issue(mk(OP_MASK_WR, 18'h0, 16'hFFFF, 2'b11, 9'd0, 8'd0));
    issue(mk(OP_MASK_WR, 18'h0, 16'h0000, 2'b00, 9'd0, 8'd0));    // no lanes, no change
    issue(mk(OP_RAM_WR, 18'h00000, 16'hFFFF, 2'b11, 9'd0, 8'd0));
    issue(mk(OP_RAM_WR, 18'h3FFFF, 16'h8000, 2'b11, 9'd0, 8'd0));
    issue(mk(OP_RAM_WR, 18'h00001, 16'hA00F, 2'b11, 9'd0, 8'd0)); // bit 15 and 13 set
    issue(mk(OP_RAM_WR, 18'd122688, 16'h9E5A, 2'b11, 9'd0, 8'd0)); // last pixel, screen 0
    issue(mk(OP_RAM_WR, 18'h20001, 16'h7FFF, 2'b11, 9'd0, 8'd0));
    issue(mk(OP_MASK_WR, 18'h0, 16'h0000, 2'b10, 9'd0, 8'd0));    // mask becomes 00ff
    issue(mk(OP_RAM_WR, 18'h00000, 16'h1234, 2'b11, 9'd0, 8'd0)); // low byte only
    issue(mk(OP_MASK_WR, 18'h0, 16'hFFFF, 2'b11, 9'd0, 8'd0));
    issue(mk(OP_RAM_RD, 18'h00000, 16'h0000, 2'b00, 9'd0, 8'd0));
    issue(mk(OP_RAM_RD, 18'h3FFFF, 16'hFFFF, 2'b11, 9'd510, 8'd255));
    issue(mk(OP_PIXEL, 18'h3FFFF, 16'hFFFF, 2'b11, 9'd0, 8'd0));
    issue(mk(OP_PIXEL, 18'h0, 16'h0, 2'b00, 9'd319, 8'd239));
    issue(mk(OP_PIXEL, 18'h0, 16'h0, 2'b00, 9'd320, 8'd0));       // just right of screen
    issue(mk(OP_PIXEL, 18'h0, 16'h0, 2'b00, 9'd0, 8'd240));       // just below screen
    issue(mk(OP_PIXEL, 18'h0, 16'h0, 2'b00, 9'd510, 8'd255));
    issue(mk(OP_CTRL_WR, 18'h0, 16'h0001, 2'b01, 9'd0, 8'd0));    // show screen 1
    issue(mk(OP_PIXEL, 18'h0, 16'h0, 2'b00, 9'd0, 8'd0));
    issue(mk(OP_CTRL_WR, 18'h0, 16'h0000, 2'b10, 9'd0, 8'd0));    // high byte only, stays
    issue(mk(OP_CTRL_WR, 18'h0, 16'hFFFE, 2'b01, 9'd0, 8'd0));    // back to screen 0
    issue(mk(OP_PIXEL, 18'h0, 16'h0, 2'b00, 9'd319, 8'd239));
    issue(mk(OP_SPARE_6, 18'h3FFFF, 16'hFFFF, 2'b11, 9'd510, 8'd255));
    issue(mk(OP_SPARE_7, 18'h3FFFF, 16'hFFFF, 2'b11, 9'd510, 8'd255));

    // random: three idling profiles; the first opens by filling RAM words
    // so that reads and on-screen pixels have defined data to land on
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 55 : 0;
      take_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 8 : 0;
      if (phase == 0) begin
        issue(mk(OP_MASK_WR, 18'($urandom), 16'hFFFF, 2'b11, 9'd0, 8'd0));
        repeat (PRELOAD_WORDS) issue(fresh_write());
      end
      repeat (RANDOM_PER_PHASE) issue(random_item());
    end
    push <= 1'b0;

    // drain; the watchdog bounds this wait
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions: %0d pixel fetches, %0d RAM reads, %0d RAM writes,",
             op_seen.sum(), op_seen[OP_PIXEL], op_seen[OP_RAM_RD], op_seen[OP_RAM_WR]);
    $display("%0d register accesses, %0d spare codes; %0d results compared over %0d words.",
             op_seen[OP_CTRL_WR] + op_seen[OP_CTRL_RD] + op_seen[OP_MASK_WR],
             op_seen[OP_SPARE_6] + op_seen[OP_SPARE_7], compared, known_addrs.size());
    if (fail_count == 0 && waiting == 0) begin
      $display("bitmap_video_layer test passed");
    end else begin
      $display("bitmap_video_layer test failed");
    end
    $finish;
  end

endmodule
